### hw/rtl/goldschmidt_reciprocal_top_defines.svh
// Assertion macros shared by the reciprocal checker
`ifndef GOLDSCHMIDT_RECIPROCAL_TOP_DEFINES_SVH
`define GOLDSCHMIDT_RECIPROCAL_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define GRCP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("grcp implication check failed");

// Next-cycle implication, off while reset is asserted
`define GRCP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("grcp next-cycle check failed");

// Reset check: a reset edge must leave the signal low
`define GRCP_ASSERT_RST(lbl, clk, rstn, sig) \
    lbl: assert property (@(posedge clk) !(rstn) |=> !(sig)) \
        else $error("grcp reset check failed");

`endif

### hw/rtl/grcp_pkg.sv
// Types, constants and fixed-point helpers of the Goldschmidt reciprocal pipeline
`timescale 1ns / 1ps
`default_nettype none

package grcp_pkg;

    localparam int IO_W        = 32;
    localparam int FRAC_BITS   = 24;
    localparam int Q_W         = 48;
    localparam int Q_FRAC      = 32;
    localparam int WIDEN_SHIFT = Q_FRAC - FRAC_BITS;
    localparam int HALF_W      = Q_W / 2;
    localparam int PROD_W      = 2 * Q_W + 1;
    localparam int SH_W        = PROD_W - Q_FRAC;
    localparam int CNT_W       = 5;
    localparam int CFG_IDX_W   = 2;

    typedef logic signed [Q_W-1:0] q_t;

    localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam q_t Q_TWO = {{(Q_W-Q_FRAC-2){1'b0}}, 2'b10, {Q_FRAC{1'b0}}};

    localparam logic [IO_W-1:0]  SEED_OFFSET_RST = 32'h0169_6969;
    localparam logic [IO_W-1:0]  SEED_SLOPE_RST  = 32'hFF87_8787;
    localparam logic [CNT_W-1:0] ITER_COUNT_RST  = 5'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED_OFFSET = 2'd0,
        CFG_SEED_SLOPE  = 2'd1,
        CFG_ITER_COUNT  = 2'd2
    } cfg_idx_t;

    // Partial products of one signed Q16.32 multiply
    typedef struct packed {
        logic signed [2*HALF_W-1:0] hh;
        logic signed [2*HALF_W:0]   hl;
        logic signed [2*HALF_W:0]   lh;
        logic [2*HALF_W-1:0]        ll;
    } pp_t;

    // One item as it moves between refinement rounds
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] rounds;
        q_t               n;
        q_t               d;
    } item_t;

    // Widen unsigned fixed point into the internal format
    function automatic q_t widen_u(input logic [IO_W-1:0] v);
        return {{(Q_W-IO_W-WIDEN_SHIFT){1'b0}}, v, {WIDEN_SHIFT{1'b0}}};
    endfunction

    // Widen signed fixed point into the internal format
    function automatic q_t widen_s(input logic [IO_W-1:0] v);
        return {{(Q_W-IO_W-WIDEN_SHIFT){v[IO_W-1]}}, v, {WIDEN_SHIFT{1'b0}}};
    endfunction

    // Saturating add or subtract
    function automatic q_t add_sat(input q_t a, input q_t b, input logic sub);
        logic signed [Q_W:0] s;
        if (sub) begin
            s = {a[Q_W-1], a} - {b[Q_W-1], b};
        end else begin
            s = {a[Q_W-1], a} + {b[Q_W-1], b};
        end
        if (s[Q_W] != s[Q_W-1]) begin
            return s[Q_W] ? Q_MIN : Q_MAX;
        end
        return s[Q_W-1:0];
    endfunction

    // Split a signed multiply into four half-width products
    function automatic pp_t mul_pp(input q_t a, input q_t b);
        logic signed [2*HALF_W-1:0] ah;
        logic signed [2*HALF_W-1:0] bh;
        logic signed [2*HALF_W:0]   ahx;
        logic signed [2*HALF_W:0]   bhx;
        logic signed [2*HALF_W:0]   alx;
        logic signed [2*HALF_W:0]   blx;
        logic [2*HALF_W-1:0]        alu;
        logic [2*HALF_W-1:0]        blu;
        pp_t                        p;
        ah   = {{HALF_W{a[Q_W-1]}}, a[Q_W-1:HALF_W]};
        bh   = {{HALF_W{b[Q_W-1]}}, b[Q_W-1:HALF_W]};
        ahx  = {{(HALF_W+1){a[Q_W-1]}}, a[Q_W-1:HALF_W]};
        bhx  = {{(HALF_W+1){b[Q_W-1]}}, b[Q_W-1:HALF_W]};
        alx  = {{(HALF_W+1){1'b0}}, a[HALF_W-1:0]};
        blx  = {{(HALF_W+1){1'b0}}, b[HALF_W-1:0]};
        alu  = {{HALF_W{1'b0}}, a[HALF_W-1:0]};
        blu  = {{HALF_W{1'b0}}, b[HALF_W-1:0]};
        p.hh = ah * bh;
        p.hl = ahx * blx;
        p.lh = alx * bhx;
        p.ll = alu * blu;
        return p;
    endfunction

    // Sum partial products, floor away the fraction, saturate
    function automatic q_t mul_sum(input pp_t p);
        logic signed [PROD_W-1:0] hh;
        logic signed [PROD_W-1:0] mid;
        logic signed [PROD_W-1:0] ll;
        logic signed [PROD_W-1:0] full;
        logic signed [SH_W-1:0]   sh;
        hh   = {{(PROD_W-2*HALF_W){p.hh[2*HALF_W-1]}}, p.hh};
        mid  = {{(PROD_W-2*HALF_W-1){p.hl[2*HALF_W]}}, p.hl}
             + {{(PROD_W-2*HALF_W-1){p.lh[2*HALF_W]}}, p.lh};
        ll   = {{(PROD_W-2*HALF_W){1'b0}}, p.ll};
        full = (hh <<< (2*HALF_W)) + (mid <<< HALF_W) + ll;
        sh   = full[PROD_W-1:Q_FRAC];
        if (&sh[SH_W-1:Q_W-1] || ~|sh[SH_W-1:Q_W-1]) begin
            return sh[Q_W-1:0];
        end
        return sh[SH_W-1] ? Q_MIN : Q_MAX;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/grcp_round.sv
// One Goldschmidt refinement round: correction factor, partial products, sum
`timescale 1ns / 1ps
`default_nettype none

module grcp_round import grcp_pkg::*; #(
    parameter int ROUND_IDX = 0
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire item_t in_item,
    output item_t      out_item
);

    localparam logic [CNT_W-1:0] ROUND_NUM = CNT_W'(ROUND_IDX);

    logic             a_valid_reg;
    logic             a_act_reg;
    logic [CNT_W-1:0] a_rounds_reg;
    q_t               a_n_reg;
    q_t               a_d_reg;
    q_t               a_f_reg;
    logic             a_act_next;
    q_t               a_f_next;

    logic             b_valid_reg;
    logic             b_act_reg;
    logic [CNT_W-1:0] b_rounds_reg;
    q_t               b_n_reg;
    q_t               b_d_reg;
    pp_t              b_ppn_reg;
    pp_t              b_ppd_reg;

    logic             c_valid_reg;
    logic [CNT_W-1:0] c_rounds_reg;
    q_t               c_n_reg;
    q_t               c_d_reg;
    q_t               c_n_next;
    q_t               c_d_next;

    // Form F = 2 - D and decide whether this round applies
    assign a_act_next = (in_item.rounds > ROUND_NUM);
    assign a_f_next   = add_sat(Q_TWO, in_item.d, 1'b1);

    // Finish both products, or pass the item through untouched
    assign c_n_next = b_act_reg ? mul_sum(b_ppn_reg) : b_n_reg;
    assign c_d_next = b_act_reg ? mul_sum(b_ppd_reg) : b_d_reg;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_item.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            a_act_reg    <= a_act_next;
            a_rounds_reg <= in_item.rounds;
            a_n_reg      <= in_item.n;
            a_d_reg      <= in_item.d;
            a_f_reg      <= a_f_next;

            b_act_reg    <= a_act_reg;
            b_rounds_reg <= a_rounds_reg;
            b_n_reg      <= a_n_reg;
            b_d_reg      <= a_d_reg;
            b_ppn_reg    <= mul_pp(a_n_reg, a_f_reg);
            b_ppd_reg    <= mul_pp(a_d_reg, a_f_reg);

            c_rounds_reg <= b_rounds_reg;
            c_n_reg      <= c_n_next;
            c_d_reg      <= c_d_next;
        end
    end

    assign out_item = '{valid: c_valid_reg, rounds: c_rounds_reg, n: c_n_reg, d: c_d_reg};

endmodule

`default_nettype wire

### hw/rtl/goldschmidt_reciprocal_top.sv
// Top level of the pipelined Goldschmidt reciprocal unit
// Throughput: one request per cycle unless the output stalls; every round has
// its own three stages, so the configured round count changes values, not timing.
// A stalled result freezes the whole pipeline; input is taken whenever it moves.
// Reset: synchronous, clears all valid bits and loads the seed and round defaults.
`timescale 1ns / 1ps
`default_nettype none

module goldschmidt_reciprocal_top import grcp_pkg::*; #(
    parameter int MAX_ITERATIONS = 24
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [IO_W-1:0]      cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [IO_W-1:0]      s_divisor,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [IO_W-1:0]           m_reciprocal,
    output logic                      m_saturated
);

    logic [IO_W-1:0]  seed_offset_reg;
    logic [IO_W-1:0]  seed_slope_reg;
    logic [CNT_W-1:0] iteration_count_reg;

    logic             en;

    logic             s1_valid_reg;
    logic [CNT_W-1:0] s1_rounds_reg;
    q_t               s1_d_reg;
    pp_t              s1_pp_reg;
    q_t               s1_d_next;

    logic             s2_valid_reg;
    logic [CNT_W-1:0] s2_rounds_reg;
    q_t               s2_d_reg;
    q_t               s2_prod_reg;

    logic             s3_valid_reg;
    logic [CNT_W-1:0] s3_rounds_reg;
    q_t               s3_d_reg;
    q_t               s3_x0_reg;

    logic             s4_valid_reg;
    logic [CNT_W-1:0] s4_rounds_reg;
    q_t               s4_x0_reg;
    pp_t              s4_pp_reg;

    logic             s5_valid_reg;
    logic [CNT_W-1:0] s5_rounds_reg;
    q_t               s5_n_reg;
    q_t               s5_d_reg;

    item_t            chain [0:MAX_ITERATIONS];
    q_t               n_fin;

    logic             m_valid_reg;
    logic [IO_W-1:0]  m_reciprocal_reg;
    logic             m_saturated_reg;
    logic [IO_W-1:0]  m_reciprocal_next;
    logic             m_saturated_next;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_offset_reg     <= SEED_OFFSET_RST;
            seed_slope_reg      <= SEED_SLOPE_RST;
            iteration_count_reg <= ITER_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SEED_OFFSET: seed_offset_reg     <= cfg_wdata;
                CFG_SEED_SLOPE:  seed_slope_reg      <= cfg_wdata;
                CFG_ITER_COUNT:  iteration_count_reg <= cfg_wdata[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Advance the whole pipeline unless the result waits on a stalled sink
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign s1_d_next = widen_u(s_divisor);

    // Seed and initial denominator valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Seed x0 = offset + slope*d, then D = d*x0 and N = x0
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_rounds_reg <= iteration_count_reg;
            s1_d_reg      <= s1_d_next;
            s1_pp_reg     <= mul_pp(widen_s(seed_slope_reg), s1_d_next);

            s2_rounds_reg <= s1_rounds_reg;
            s2_d_reg      <= s1_d_reg;
            s2_prod_reg   <= mul_sum(s1_pp_reg);

            s3_rounds_reg <= s2_rounds_reg;
            s3_d_reg      <= s2_d_reg;
            s3_x0_reg     <= add_sat(widen_u(seed_offset_reg), s2_prod_reg, 1'b0);

            s4_rounds_reg <= s3_rounds_reg;
            s4_x0_reg     <= s3_x0_reg;
            s4_pp_reg     <= mul_pp(s3_d_reg, s3_x0_reg);

            s5_rounds_reg <= s4_rounds_reg;
            s5_n_reg      <= s4_x0_reg;
            s5_d_reg      <= mul_sum(s4_pp_reg);
        end
    end

    assign chain[0] = '{valid: s5_valid_reg, rounds: s5_rounds_reg, n: s5_n_reg, d: s5_d_reg};

    // Refinement rounds, one three-stage slice each
    for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_round
        grcp_round #(
            .ROUND_IDX (k)
        ) u_round (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_item  (chain[k]),
            .out_item (chain[k+1])
        );
    end

    assign n_fin = chain[MAX_ITERATIONS].n;

    // Clamp N to the unsigned output range
    always_comb begin
        if (n_fin[Q_W-1]) begin
            m_reciprocal_next = '0;
            m_saturated_next  = 1'b1;
        end else if (|n_fin[Q_W-2:WIDEN_SHIFT+IO_W]) begin
            m_reciprocal_next = '1;
            m_saturated_next  = 1'b1;
        end else begin
            m_reciprocal_next = n_fin[WIDEN_SHIFT+IO_W-1:WIDEN_SHIFT];
            m_saturated_next  = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= chain[MAX_ITERATIONS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reciprocal_reg <= m_reciprocal_next;
            m_saturated_reg  <= m_saturated_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_reciprocal = m_reciprocal_reg;
    assign m_saturated  = m_saturated_reg;

endmodule

`default_nettype wire

### hw/rtl/grcp_checker.sv
// Port-level checks of the reciprocal unit and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "goldschmidt_reciprocal_top_defines.svh"

module grcp_checker import grcp_pkg::*; (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_ready,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire logic [IO_W-1:0] m_reciprocal,
    input wire logic            m_saturated
);

    logic stall_out;
    logic sat_out;

    assign stall_out = m_valid && !m_ready;
    assign sat_out   = m_valid && m_saturated;

    // Hold a stalled result
    `GRCP_ASSERT_NXT(a_out_hold, aclk, aresetn, stall_out, m_valid && $stable({m_reciprocal, m_saturated}))

    // A clamped result is pinned to one end of the range
    `GRCP_ASSERT_IMP(a_sat_value, aclk, aresetn, sat_out, m_reciprocal == '0 || m_reciprocal == '1)

    // Take a new request whenever the output can move
    `GRCP_ASSERT_IMP(a_in_flow, aclk, aresetn, !m_valid || m_ready, s_ready)

    // Drop any result on reset
    `GRCP_ASSERT_RST(a_rst_out, aclk, aresetn, m_valid)

endmodule

bind goldschmidt_reciprocal_top grcp_checker u_grcp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_reciprocal (m_reciprocal),
    .m_saturated  (m_saturated)
);

`default_nettype wire
